/* hdl/g2rx_pkg.sv */
// g2rx_pkg: types, character codes and expansion functions of the glob to regex stream.
// Used by the front end, the command queue, the back end and the top level.
// Depends on nothing.
package g2rx_pkg;

	// command queue depth
	localparam int QDepth = 4;
	localparam int QPtrW  = $clog2(QDepth);
	localparam int QCntW  = $clog2(QDepth + 1);

	// character codes
	localparam logic [7:0] ChLBrack = 8'h5B;  // [
	localparam logic [7:0] ChRBrack = 8'h5D;  // ]
	localparam logic [7:0] ChCaret  = 8'h5E;  // ^
	localparam logic [7:0] ChSlash  = 8'h2F;  // /
	localparam logic [7:0] ChStar   = 8'h2A;  // *
	localparam logic [7:0] ChDot    = 8'h2E;  // .
	localparam logic [7:0] ChBslash = 8'h5C;  // backslash
	localparam logic [7:0] ChDollar = 8'h24;  // $
	localparam logic [7:0] ChQmark  = 8'h3F;  // ?
	localparam logic [7:0] ChPlus   = 8'h2B;  // +
	localparam logic [7:0] ChLParen = 8'h28;  // (
	localparam logic [7:0] ChRParen = 8'h29;  // )
	localparam logic [7:0] ChPipe   = 8'h7C;  // |
	localparam logic [7:0] ChLBrace = 8'h7B;  // {
	localparam logic [7:0] ChRBrace = 8'h7D;  // }

	// lengths of the fixed expansions
	localparam logic [2:0] LenStar  = 3'd5;   // [^/]*
	localparam logic [2:0] LenQmark = 3'd4;   // [^/]
	localparam logic [2:0] LenPair  = 3'd2;   // .*
	localparam logic [2:0] LenEsc   = 3'd2;   // \c
	localparam logic [2:0] LenOne   = 3'd1;

	// what the pattern byte itself expands to
	typedef enum logic [2:0] {
		BODY_NONE,
		BODY_COPY,
		BODY_ESC,
		BODY_QMARK,
		BODY_PAIR
	} body_t;

	// output segments of one command, in emission order
	typedef enum logic [2:0] {
		SEG_ANCHOR = 3'd0,
		SEG_PRE    = 3'd1,
		SEG_BODY   = 3'd2,
		SEG_POST   = 3'd3,
		SEG_DOLLAR = 3'd4
	} seg_t;

	localparam int NumSegs = 5;

	// classified item, passed from front to back
	typedef struct packed {
		logic       anchor;     // leading '^'
		logic       pre_star;   // flush of a pending star before the body
		body_t      body;
		logic [7:0] ch;
		logic       post_star;  // flush of a pending star at pattern end
		logic       dollar;     // closing '$'
	} cmd_t;

	// result of a search for the next present segment
	typedef struct packed {
		logic found;
		seg_t seg;
	} seg_hit_t;

	function automatic logic needs_escape(input logic [7:0] c);
		logic r;
		case (c) inside
			ChDot, ChPlus, ChLParen, ChRParen, ChPipe,
			ChLBrace, ChRBrace, ChCaret, ChDollar: r = 1'b1;
			default:                               r = 1'b0;
		endcase
		return r;
	endfunction

	function automatic logic [2:0] body_len(input body_t b);
		logic [2:0] r;
		unique case (b)
			BODY_NONE:  r = 3'd0;
			BODY_COPY:  r = LenOne;
			BODY_ESC:   r = LenEsc;
			BODY_QMARK: r = LenQmark;
			BODY_PAIR:  r = LenPair;
			default:    r = 3'd0;
		endcase
		return r;
	endfunction

	// number of bytes a segment emits, zero when absent
	function automatic logic [2:0] seg_len(input cmd_t c, input seg_t s);
		logic [2:0] r;
		unique case (s)
			SEG_ANCHOR: r = c.anchor    ? LenOne  : 3'd0;
			SEG_PRE:    r = c.pre_star  ? LenStar : 3'd0;
			SEG_BODY:   r = body_len(c.body);
			SEG_POST:   r = c.post_star ? LenStar : 3'd0;
			SEG_DOLLAR: r = c.dollar    ? LenOne  : 3'd0;
			default:    r = 3'd0;
		endcase
		return r;
	endfunction

	// byte of "[^/]*" (also serves "[^/]")
	function automatic logic [7:0] class_byte(input logic [2:0] idx);
		logic [7:0] r;
		case (idx)
			3'd0:    r = ChLBrack;
			3'd1:    r = ChCaret;
			3'd2:    r = ChSlash;
			3'd3:    r = ChRBrack;
			default: r = ChStar;
		endcase
		return r;
	endfunction

	function automatic logic [7:0] seg_byte(input cmd_t c, input seg_t s,
			input logic [2:0] idx);
		logic [7:0] r;
		unique case (s)
			SEG_ANCHOR: r = ChCaret;
			SEG_PRE,
			SEG_POST:   r = class_byte(idx);
			SEG_DOLLAR: r = ChDollar;
			SEG_BODY: begin
				unique case (c.body)
					BODY_ESC:   r = (idx == 3'd0) ? ChBslash : c.ch;
					BODY_QMARK: r = class_byte(idx);
					BODY_PAIR:  r = (idx == 3'd0) ? ChDot : ChStar;
					default:    r = c.ch;
				endcase
			end
			default:    r = c.ch;
		endcase
		return r;
	endfunction

	// first present segment at or after start
	function automatic seg_hit_t find_seg(input cmd_t c, input logic [2:0] start);
		seg_hit_t h;
		logic [2:0] s3;
		h.found = 1'b0;
		h.seg   = SEG_DOLLAR;
		for (int s = NumSegs - 1; s >= 0; s--) begin
			s3 = 3'(s);
			if (s3 >= start && seg_len(c, seg_t'(s3)) != 3'd0) begin
				h.found = 1'b1;
				h.seg   = seg_t'(s3);
			end
		end
		return h;
	endfunction

endpackage

/* hdl/g2rx_ifs.sv */
// g2rx_ifs: valid/ready channels of the glob to regex stream.
// Pattern channel carries glob bytes in, regex channel carries regex bytes out.
// Depends on nothing.
interface g2rx_pattern_if;
	logic       valid;
	logic       ready;
	logic [7:0] pattern_char;
	logic       has_char;
	logic       is_last;

	modport source (output valid, pattern_char, has_char, is_last, input ready);
	modport sink   (input valid, pattern_char, has_char, is_last, output ready);
endinterface

interface g2rx_regex_if;
	logic       valid;
	logic       ready;
	logic [7:0] regex_char;
	logic       end_of_run;
	logic       end_of_regex;

	modport source (output valid, regex_char, end_of_run, end_of_regex, input ready);
	modport sink   (input valid, regex_char, end_of_run, end_of_regex, output ready);
endinterface

/* hdl/g2rx_front.sv */
// g2rx_front: accepts glob bytes, tracks pattern state and classifies each item
// into a command for the back end. Depends on g2rx_pkg and g2rx_ifs.
module g2rx_front (
	input  logic                  clk,
	input  logic                  arst_n,
	g2rx_pattern_if.sink          pattern,
	input  logic                  q_full,
	output logic                  q_push,
	output g2rx_pkg::cmd_t        q_data
);

	logic at_start_q;
	logic star_q;
	logic class_q;

	logic            take;
	logic            active;
	logic            star_nx;
	logic            class_nx;
	g2rx_pkg::cmd_t  cmd;

	assign pattern.ready = !q_full;
	assign take   = pattern.valid && pattern.ready;
	assign active = pattern.has_char || pattern.is_last;

	// classify the byte against the current state
	always_comb begin
		cmd.anchor    = at_start_q;
		cmd.pre_star  = 1'b0;
		cmd.body      = g2rx_pkg::BODY_NONE;
		cmd.ch        = pattern.pattern_char;
		cmd.post_star = 1'b0;
		cmd.dollar    = pattern.is_last;
		star_nx       = star_q;
		class_nx      = class_q;
		if (pattern.has_char) begin
			if (class_q) begin
				cmd.body = g2rx_pkg::BODY_COPY;
				if (pattern.pattern_char == g2rx_pkg::ChRBrack) begin
					class_nx = 1'b0;
				end
			end else if (pattern.pattern_char == g2rx_pkg::ChStar) begin
				if (star_q) begin
					cmd.body = g2rx_pkg::BODY_PAIR;
					star_nx  = 1'b0;
				end else begin
					star_nx  = 1'b1;
				end
			end else begin
				cmd.pre_star = star_q;
				star_nx      = 1'b0;
				if (pattern.pattern_char == g2rx_pkg::ChQmark) begin
					cmd.body = g2rx_pkg::BODY_QMARK;
				end else if (g2rx_pkg::needs_escape(pattern.pattern_char)) begin
					cmd.body = g2rx_pkg::BODY_ESC;
				end else begin
					cmd.body = g2rx_pkg::BODY_COPY;
					if (pattern.pattern_char == g2rx_pkg::ChLBrack) begin
						class_nx = 1'b1;
					end
				end
			end
		end
		// flush a star left pending at pattern end
		cmd.post_star = pattern.is_last && star_nx;
	end

	// enqueue only items that produce output
	assign q_data = cmd;
	assign q_push = take && active &&
		(cmd.anchor || cmd.pre_star || cmd.body != g2rx_pkg::BODY_NONE || cmd.dollar);

	// advance pattern state on each transfer that carries a byte or is_last
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			at_start_q <= 1'b1;
			star_q     <= 1'b0;
			class_q    <= 1'b0;
		end else if (take && active) begin
			if (pattern.is_last) begin
				at_start_q <= 1'b1;
				star_q     <= 1'b0;
				class_q    <= 1'b0;
			end else begin
				at_start_q <= 1'b0;
				star_q     <= star_nx;
				class_q    <= class_nx;
			end
		end
	end

endmodule

/* hdl/g2rx_queue.sv */
// g2rx_queue: short command FIFO between front and back end.
// Depends on g2rx_pkg.
module g2rx_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  g2rx_pkg::cmd_t  push_data,
	output logic            full,
	input  logic            pop,
	output logic            head_valid,
	output g2rx_pkg::cmd_t  head_data
);

	g2rx_pkg::cmd_t                     entries_q [g2rx_pkg::QDepth];
	logic [g2rx_pkg::QPtrW-1:0]         wr_ptr_q;
	logic [g2rx_pkg::QPtrW-1:0]         rd_ptr_q;
	logic [g2rx_pkg::QCntW-1:0]         count_q;
	logic                               do_push;
	logic                               do_pop;

	assign full       = count_q == g2rx_pkg::QCntW'(g2rx_pkg::QDepth);
	assign head_valid = count_q != '0;
	assign head_data  = entries_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	// store payload
	always_ff @(posedge clk) begin
		if (do_push) begin
			entries_q[wr_ptr_q] <= push_data;
		end
	end

	// advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

/* hdl/g2rx_back.sv */
// g2rx_back: expands commands into regex bytes, one per cycle when not
// stalled, via a registered output stage. Depends on g2rx_pkg and g2rx_ifs.
module g2rx_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            q_valid,
	input  g2rx_pkg::cmd_t  q_data,
	output logic            q_pop,
	g2rx_regex_if.source    regex
);

	g2rx_pkg::cmd_t      cmd_q;
	logic                cmd_valid_q;
	g2rx_pkg::seg_t      seg_q;
	logic [2:0]          idx_q;
	logic                out_valid_q;
	logic [7:0]          out_char_q;
	logic                out_run_q;
	logic                out_regex_q;

	logic                  step;
	logic                  seg_done;
	logic                  last_byte;
	logic                  load;
	g2rx_pkg::seg_hit_t    nxt;
	g2rx_pkg::seg_hit_t    first;

	assign step      = cmd_valid_q && (!out_valid_q || regex.ready);
	assign seg_done  = idx_q == (g2rx_pkg::seg_len(cmd_q, seg_q) - 3'd1);
	assign nxt       = g2rx_pkg::find_seg(cmd_q, 3'(seg_q) + 3'd1);
	assign first     = g2rx_pkg::find_seg(q_data, 3'd0);
	assign last_byte = seg_done && !nxt.found;
	assign load      = !cmd_valid_q || (step && last_byte);
	assign q_pop     = load && q_valid;

	// walk segments of the current command, fetch the next one on completion
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_valid_q <= 1'b0;
			seg_q       <= g2rx_pkg::SEG_ANCHOR;
			idx_q       <= '0;
		end else if (load) begin
			cmd_valid_q <= q_valid;
			seg_q       <= first.seg;
			idx_q       <= '0;
		end else if (step) begin
			if (seg_done) begin
				seg_q <= nxt.seg;
				idx_q <= '0;
			end else begin
				idx_q <= idx_q + 3'd1;
			end
		end
	end

	// hold the command payload
	always_ff @(posedge clk) begin
		if (load) begin
			cmd_q <= q_data;
		end
	end

	// output register: hold while stalled, drop after transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step) begin
			out_valid_q <= 1'b1;
		end else if (regex.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			out_char_q  <= g2rx_pkg::seg_byte(cmd_q, seg_q, idx_q);
			out_run_q   <= last_byte;
			out_regex_q <= seg_q == g2rx_pkg::SEG_DOLLAR;
		end
	end

	assign regex.valid        = out_valid_q;
	assign regex.regex_char   = out_char_q;
	assign regex.end_of_run   = out_run_q;
	assign regex.end_of_regex = out_regex_q;

endmodule

/* hdl/glob_to_regex_stream_top.sv */
// glob_to_regex_stream_top: converts a glob pattern stream into an anchored
// POSIX extended regex stream. Depends on g2rx_pkg, g2rx_ifs, g2rx_front,
// g2rx_queue and g2rx_back.
//
// Usage:
//   pattern channel: one glob byte per transfer (pattern_char, has_char,
//   is_last). is_last closes the pattern; has_char = 0 with is_last = 1 gives
//   an empty pattern, has_char = 0 alone is consumed with no effect.
//   regex channel: one regex byte per transfer; end_of_run marks the last byte
//   caused by an input item, end_of_regex marks the closing '$'.
//   Path: an item passes through the command queue, the command register and
//   the output register of the back end before its first byte appears.
//   Throughput: the back end emits one byte per cycle while regex.ready is high;
//   an item expands to none to 10 bytes, and a four-entry command queue lets
//   input keep flowing while a long one drains.
//   Reset: arst_n clears pattern state (anchor owed, no star, no class), the
//   queue and the output register; the block is ready right after reset.
//   Stall: when regex.ready is low, the output byte holds; the queue fills and
//   then pattern.ready drops until the receiver resumes.
module glob_to_regex_stream_top (
	input  logic             clk,
	input  logic             arst_n,
	g2rx_pattern_if.sink     pattern,
	g2rx_regex_if.source     regex
);

	logic            q_full;
	logic            q_push;
	g2rx_pkg::cmd_t  q_in;
	logic            q_pop;
	logic            q_valid;
	g2rx_pkg::cmd_t  q_head;

	g2rx_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.pattern(pattern),
		.q_full (q_full),
		.q_push (q_push),
		.q_data (q_in)
	);

	g2rx_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_in),
		.full      (q_full),
		.pop       (q_pop),
		.head_valid(q_valid),
		.head_data (q_head)
	);

	g2rx_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.q_valid(q_valid),
		.q_data (q_head),
		.q_pop  (q_pop),
		.regex  (regex)
	);

endmodule
